### design/ohv_pkg.sv
`default_nettype none
package ohv_pkg;

    localparam int NUM_ST   = 28;
    localparam int NO_PARENT = 28;
    localparam int NEVER_W  = 21;
    localparam int EMIT_W   = 24;
    localparam int GROUP_SUMMARY = 4;

    // base codes
    localparam logic [2:0] BASE_T   = 3'd0;
    localparam logic [2:0] BASE_A   = 3'd2;
    localparam logic [2:0] BASE_G   = 3'd3;
    localparam logic [2:0] BASE_GAP = 3'd5;

    // input item after classification by the front end
    typedef struct packed {
        logic signed [EMIT_W-1:0] utr5;
        logic signed [EMIT_W-1:0] utr3;
        logic signed [EMIT_W-1:0] kozak;
        logic signed [EMIT_W-1:0] codon;
        logic                     gap;
        logic                     stop;
        logic                     last;
    } t_column;

    localparam int COL_W = $bits(t_column);

endpackage
`default_nettype wire

### design/ohv_front.sv
`default_nettype none
// Accepts columns, tracks the last two target bases and flags stop codons.
module ohv_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [2:0]          i_base,
    input  wire logic [4*ohv_pkg::EMIT_W-1:0] i_emit,
    input  wire logic                i_last,
    output logic                     o_push,
    output ohv_pkg::t_column         o_col,
    input  wire logic                i_full
);
    logic [2:0] r_b0, r_b1;
    logic [1:0] r_seen;
    logic       w_stop;
    logic       w_acc;

    assign o_ready = !i_full;
    assign w_acc   = i_valid && !i_full;
    assign o_push  = w_acc;

    // stop codon from prior two bases and this one, gaps included
    always_comb begin
        w_stop = 1'b0;
        if (r_seen == 2'd2 && r_b1 == ohv_pkg::BASE_T) begin
            if (r_b0 == ohv_pkg::BASE_A && (i_base == ohv_pkg::BASE_G ||
                                            i_base == ohv_pkg::BASE_A))
                w_stop = 1'b1;
            else if (r_b0 == ohv_pkg::BASE_G && i_base == ohv_pkg::BASE_A)
                w_stop = 1'b1;
        end
    end

    assign o_col.utr5  = i_emit[0*ohv_pkg::EMIT_W +: ohv_pkg::EMIT_W];
    assign o_col.utr3  = i_emit[1*ohv_pkg::EMIT_W +: ohv_pkg::EMIT_W];
    assign o_col.kozak = i_emit[2*ohv_pkg::EMIT_W +: ohv_pkg::EMIT_W];
    assign o_col.codon = i_emit[3*ohv_pkg::EMIT_W +: ohv_pkg::EMIT_W];
    assign o_col.gap   = (i_base == ohv_pkg::BASE_GAP);
    assign o_col.stop  = w_stop;
    assign o_col.last  = i_last;

    // base history, cleared after the last column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= '0; r_b1 <= '0; r_seen <= '0;
        end else if (w_acc) begin
            if (i_last) begin
                r_b0 <= '0; r_b1 <= '0; r_seen <= '0;
            end else begin
                r_b1 <= r_b0;
                r_b0 <= i_base;
                if (r_seen != 2'd2) r_seen <= r_seen + 2'd1;
            end
        end
    end
endmodule
`default_nettype wire

### design/ohv_fifo.sv
`default_nettype none
// Two-entry queue between front and back.
module ohv_fifo (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire ohv_pkg::t_column i_data,
    output logic                  o_full,
    output logic                  o_valid,
    input  wire logic             i_pop,
    output ohv_pkg::t_column      o_data
);
    ohv_pkg::t_column r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    // queue never overflows, underflows or counts past two
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full);
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid);
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2);
endmodule
`default_nettype wire

### design/ohv_back.sv
`default_nettype none
// Add-compare-select for one column, then streams four pointer groups and
// an optional summary item through an output register.
module ohv_back #(
    parameter int SCORE_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic signed [ohv_pkg::NEVER_W-1:0] i_never,
    input  wire logic                 i_valid,
    output logic                      o_pop,
    input  wire ohv_pkg::t_column     i_col,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [2:0]                o_group,
    output logic [34:0]               o_parents,
    output logic [4:0]                o_best_state,
    output logic signed [31:0]        o_best_score,
    output logic                      o_last
);
    localparam int SB = SCORE_BITS;
    localparam int WB = SB + 2;
    localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};
    localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_OUT  = 3'b010,
        ST_SUM  = 3'b100
    } t_state;

    t_state r_state;
    logic signed [SB-1:0] r_sc [ohv_pkg::NUM_ST];
    logic signed [SB-1:0] w_nx [ohv_pkg::NUM_ST];
    logic [4:0]  r_ptr [ohv_pkg::NUM_ST];
    logic [4:0]  w_pp  [ohv_pkg::NUM_ST];
    logic [1:0]  r_grp;
    logic        r_last;
    logic [4:0]  r_bs_st, r_bs_i;
    logic signed [SB-1:0] r_bs;
    logic        r_ov;
    logic        w_load;
    logic signed [SB-1:0] w_never, w_notins, w_isins, w_stop;

    function automatic logic signed [SB-1:0] sat(input logic signed [WB-1:0] v);
        logic signed [WB-1:0] lo, hi;
        lo = WB'(SMIN);
        hi = WB'(SMAX);
        if (v < lo) sat = SMIN;
        else if (v > hi) sat = SMAX;
        else sat = v[SB-1:0];
    endfunction

    function automatic logic signed [SB-1:0] cand(input logic signed [SB-1:0] sc,
                                                  input logic signed [SB-1:0] em,
                                                  input logic signed [15:0] tr);
        cand = sat(WB'(sc) + WB'(em) + WB'(tr));
    endfunction

    assign w_never  = SB'(i_never);
    assign w_notins = i_col.gap ? w_never : '0;
    assign w_isins  = i_col.gap ? '0 : w_never;
    assign w_stop   = i_col.stop ? '0 : w_never;

    // ACS for all 28 states from the constant trellis
    always_comb begin
        logic signed [SB-1:0] c;
        logic signed [SB-1:0] b;
        logic [4:0] p;
        for (int s = 0; s < ohv_pkg::NUM_ST; s++) begin
            w_nx[s] = SMIN;
            w_pp[s] = 5'(ohv_pkg::NO_PARENT);
        end
        c = cand(r_sc[0], SB'(i_col.utr5), -16'sd3);
        if (c > SMIN) begin w_nx[0] = c; w_pp[0] = 5'd0; end
        b = SMIN; p = 5'(ohv_pkg::NO_PARENT);
        c = cand(r_sc[1], SB'(i_col.utr3), 16'sd0);  if (c > b) begin b = c; p = 5'd1; end
        c = cand(r_sc[15], SB'(i_col.utr3), 16'sd0); if (c > b) begin b = c; p = 5'd15; end
        w_nx[1] = b; w_pp[1] = p;
        c = cand(r_sc[0], '0, -16'sd1179);
        if (c > SMIN) begin w_nx[2] = c; w_pp[2] = 5'd0; end
        for (int s = 3; s <= 8; s++) begin
            c = cand(r_sc[s-1], '0, 16'sd0);
            if (c > SMIN) begin w_nx[s] = c; w_pp[s] = 5'(s-1); end
        end
        c = cand(r_sc[8], SB'(i_col.kozak), 16'sd0);
        if (c > SMIN) begin w_nx[9] = c; w_pp[9] = 5'd8; end
        // state 10
        b = SMIN; p = 5'(ohv_pkg::NO_PARENT);
        c = cand(r_sc[12], w_notins, -16'sd1); if (c > b) begin b = c; p = 5'd12; end
        c = cand(r_sc[9], '0, 16'sd0);         if (c > b) begin b = c; p = 5'd9; end
        c = cand(r_sc[18], w_notins, -16'sd3); if (c > b) begin b = c; p = 5'd18; end
        c = cand(r_sc[27], w_notins, -16'sd57); if (c > b) begin b = c; p = 5'd27; end
        w_nx[10] = b; w_pp[10] = p;
        // state 11
        b = SMIN; p = 5'(ohv_pkg::NO_PARENT);
        c = cand(r_sc[10], w_notins, 16'sd0);  if (c > b) begin b = c; p = 5'd10; end
        c = cand(r_sc[16], w_notins, -16'sd3); if (c > b) begin b = c; p = 5'd16; end
        c = cand(r_sc[21], w_notins, -16'sd57); if (c > b) begin b = c; p = 5'd21; end
        w_nx[11] = b; w_pp[11] = p;
        // state 12
        b = SMIN; p = 5'(ohv_pkg::NO_PARENT);
        c = cand(r_sc[11], SB'(i_col.codon), 16'sd0); if (c > b) begin b = c; p = 5'd11; end
        c = cand(r_sc[17], w_notins, -16'sd3); if (c > b) begin b = c; p = 5'd17; end
        c = cand(r_sc[24], w_notins, -16'sd57); if (c > b) begin b = c; p = 5'd24; end
        w_nx[12] = b; w_pp[12] = p;
        c = cand(r_sc[12], '0, -16'sd1487);
        if (c > SMIN) begin w_nx[13] = c; w_pp[13] = 5'd12; end
        c = cand(r_sc[13], '0, 16'sd0);
        if (c > SMIN) begin w_nx[14] = c; w_pp[14] = 5'd13; end
        c = cand(r_sc[14], w_stop, 16'sd0);
        if (c > SMIN) begin w_nx[15] = c; w_pp[15] = 5'd14; end
        // insert self-loops 16..18
        for (int k = 0; k < 3; k++) begin
            b = SMIN; p = 5'(ohv_pkg::NO_PARENT);
            c = cand(r_sc[10+k], w_isins, -16'sd2358);
            if (c > b) begin b = c; p = 5'(10+k); end
            c = cand(r_sc[16+k], w_isins, -16'sd1179);
            if (c > b) begin b = c; p = 5'(16+k); end
            w_nx[16+k] = b; w_pp[16+k] = p;
        end
        // triplet inserts 19..27
        for (int k = 0; k < 3; k++) begin
            b = SMIN; p = 5'(ohv_pkg::NO_PARENT);
            c = cand(r_sc[10+k], w_isins, -16'sd1768);
            if (c > b) begin b = c; p = 5'(10+k); end
            c = cand(r_sc[21+3*k], w_isins, -16'sd412);
            if (c > b) begin b = c; p = 5'(21+3*k); end
            w_nx[19+3*k] = b; w_pp[19+3*k] = p;
            c = cand(r_sc[19+3*k], w_isins, 16'sd0);
            if (c > SMIN) begin w_nx[20+3*k] = c; w_pp[20+3*k] = 5'(19+3*k); end
            c = cand(r_sc[20+3*k], w_isins, 16'sd0);
            if (c > SMIN) begin w_nx[21+3*k] = c; w_pp[21+3*k] = 5'(20+3*k); end
        end
    end

    // a column is taken once the last group of the previous one leaves
    // and the initial scores are in place
    assign w_load = i_valid && !r_ov && ((r_state == ST_IDLE) ||
                    (r_state == ST_OUT && r_grp == 2'd3 && !r_last && i_ready)) &&
                    !(r_state == ST_OUT && r_last);
    assign o_pop  = w_load;

    // scores, pointers and sequencing
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            for (int s = 0; s < ohv_pkg::NUM_ST; s++) r_ptr[s] <= w_pp[s];
            r_last <= i_col.last;
        end
        if (r_state == ST_SUM && r_bs_i != 5'(ohv_pkg::NUM_ST)) begin
            if (r_sc[r_bs_i] > r_bs) begin
                r_bs <= r_sc[r_bs_i];
                r_bs_st <= r_bs_i;
            end
        end else if (r_state == ST_OUT && r_grp == 2'd3 && i_ready) begin
            r_bs <= r_sc[0];
            r_bs_st <= 5'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_grp   <= '0;
            r_bs_i  <= '0;
            for (int s = 0; s < ohv_pkg::NUM_ST; s++) r_sc[s] <= SMIN;
            r_ov <= 1'b1;
        end else begin
            if (r_ov) begin
                // initial scores
                for (int s = 0; s < ohv_pkg::NUM_ST; s++) r_sc[s] <= w_never;
                r_sc[0]  <= -SB'(131);
                r_sc[10] <= -SB'(589);
                r_sc[11] <= -SB'(589);
                r_sc[12] <= -SB'(589);
                r_sc[1]  <= -SB'(412);
                r_ov <= 1'b0;
            end else if (w_load) begin
                for (int s = 0; s < ohv_pkg::NUM_ST; s++) r_sc[s] <= w_nx[s];
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_load) begin r_state <= ST_OUT; r_grp <= '0; end
                end
                ST_OUT: begin
                    if (i_ready) begin
                        if (r_grp != 2'd3) r_grp <= r_grp + 2'd1;
                        else if (r_last) begin
                            r_state <= ST_SUM; r_bs_i <= 5'd1;
                        end else if (w_load) r_grp <= '0;
                        else r_state <= ST_IDLE;
                    end
                end
                ST_SUM: begin
                    // linear scan of 27 states, then the item itself
                    if (r_bs_i != 5'(ohv_pkg::NUM_ST)) r_bs_i <= r_bs_i + 5'd1;
                    else if (i_ready) begin
                        r_state <= ST_IDLE;
                        r_ov <= 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output fields; summary valid once the scan finishes
    always_comb begin
        o_valid = 1'b0;
        o_group = '0;
        o_parents = '0;
        o_best_state = '0;
        o_best_score = '0;
        o_last = 1'b0;
        case (r_state)
            ST_OUT: begin
                o_valid = 1'b1;
                o_group = {1'b0, r_grp};
                for (int j = 0; j < 7; j++)
                    o_parents[5*j +: 5] = r_ptr[7*r_grp + j];
                o_last = (r_grp == 2'd3) && !r_last;
            end
            ST_SUM: begin
                o_valid = (r_bs_i == 5'(ohv_pkg::NUM_ST));
                o_group = 3'(ohv_pkg::GROUP_SUMMARY);
                for (int j = 0; j < 7; j++)
                    o_parents[5*j +: 5] = 5'(ohv_pkg::NO_PARENT);
                o_best_state = r_bs_st;
                if (SB > 32) begin
                    if (r_bs > SB'(32'sh7fffffff)) o_best_score = 32'sh7fffffff;
                    else if (r_bs < -SB'(33'sh80000000))
                        o_best_score = 32'sh80000000;
                    else o_best_score = 32'(r_bs);
                end else o_best_score = 32'(r_bs);
                o_last = 1'b1;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

### design/orf_hmm_viterbi_forward.sv
`default_nettype none
// Viterbi forward pass over a 28-state open-reading-frame model. Each column
// produces four back-pointer groups from one output register, one per cycle
// when the output is ready. A last column adds a summary item after a scan
// of the scores for the best state, and once that item is taken the initial
// scores are restored. A two-entry queue lets the input accept up to two
// columns while results wait.
module orf_hmm_viterbi_forward #(
    parameter int SCORE_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [20:0] i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // target_base, utr5_emit, utr3_emit, kozak_emit, codon_emit, pad
    input  wire logic [103:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // parent_0..parent_6, best_state, best_score
    output logic [71:0]      m_axis_tdata,
    // group
    output logic [2:0]       m_axis_tuser,
    output logic             m_axis_tlast
);
    logic signed [20:0] r_never;
    logic w_push, w_full, w_qv, w_pop;
    ohv_pkg::t_column w_in, w_q;
    logic [34:0] w_par;
    logic [4:0]  w_bst;
    logic signed [31:0] w_bsc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_never <= -21'sd58947;
        else if (i_cfg_we) r_never <= i_cfg_wdata;
    end

    ohv_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_base(s_axis_tdata[2:0]), .i_emit(s_axis_tdata[98:3]),
        .i_last(s_axis_tlast), .o_push(w_push), .o_col(w_in), .i_full(w_full)
    );

    ohv_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_data(w_in),
        .o_full(w_full), .o_valid(w_qv), .i_pop(w_pop), .o_data(w_q)
    );

    ohv_back #(.SCORE_BITS(SCORE_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_never(r_never),
        .i_valid(w_qv), .o_pop(w_pop), .i_col(w_q),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_group(m_axis_tuser), .o_parents(w_par), .o_best_state(w_bst),
        .o_best_score(w_bsc), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {w_bsc, w_bst, w_par};
endmodule
`default_nettype wire

### tb/orf_hmm_viterbi_forward_test.sv
`timescale 1ns / 1ps
module orf_hmm_viterbi_forward_test;

    localparam int SB = 32;
    localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};
    localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
    localparam int NEVER_RST = -58947;

    // emission selectors per edge
    typedef enum int {K_NONE, K_UTR5, K_UTR3, K_KOZ, K_CODON, K_NOTINS, K_ISINS, K_STOP} t_kind;

    typedef struct {
        logic [2:0]  grp;
        logic [34:0] parents;
        logic [4:0]  best;
        logic [31:0] score;
        logic        last;
    } t_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [20:0]  i_cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    wire          s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic         s_axis_tlast = 1'b0;
    wire          m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    wire  [71:0]  m_axis_tdata;
    wire  [2:0]   m_axis_tuser;
    wire          m_axis_tlast;

    orf_hmm_viterbi_forward dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // edge table: destination, source, transition, emission kind
    int     e_dst[42] = '{0,1,1,2,3,4,5,6,7,8,9,10,10,10,10,11,11,11,12,12,12,
                          13,14,15,16,16,17,17,18,18,19,19,20,21,22,22,23,24,25,25,26,27};
    int     e_src[42] = '{0,1,15,0,2,3,4,5,6,7,8,12,9,18,27,10,16,21,11,17,24,
                          12,13,14,10,16,11,17,12,18,10,21,19,20,11,24,22,23,12,27,25,26};
    int     e_tr[42]  = '{-3,0,0,-1179,0,0,0,0,0,0,0,-1,0,-3,-57,0,-3,-57,0,-3,-57,
                          -1487,0,0,-2358,-1179,-2358,-1179,-2358,-1179,-1768,-412,
                          0,0,-1768,-412,0,0,-1768,-412,0,0};
    t_kind  e_kind[42] = '{K_UTR5,K_UTR3,K_UTR3,K_NONE,K_NONE,K_NONE,K_NONE,K_NONE,K_NONE,
                          K_NONE,K_KOZ,K_NOTINS,K_NONE,K_NOTINS,K_NOTINS,K_NOTINS,K_NOTINS,
                          K_NOTINS,K_CODON,K_NOTINS,K_NOTINS,K_NONE,K_NONE,K_STOP,
                          K_ISINS,K_ISINS,K_ISINS,K_ISINS,K_ISINS,K_ISINS,K_ISINS,K_ISINS,
                          K_ISINS,K_ISINS,K_ISINS,K_ISINS,K_ISINS,K_ISINS,K_ISINS,K_ISINS,
                          K_ISINS,K_ISINS};

    // predictor state
    longint      never_val;
    longint      path[ohv_pkg::NUM_ST];
    logic [2:0]  base_prev, base_prev2;
    int          cols_seen;

    t_result expected_results[$];
    int      mismatches = 0;
    bit      failed = 0;

    function automatic longint clamp(longint v);
        if (v < longint'(SMIN)) return longint'(SMIN);
        if (v > longint'(SMAX)) return longint'(SMAX);
        return v;
    endfunction

    function automatic void restart_scores();
        for (int i = 0; i < ohv_pkg::NUM_ST; i++) path[i] = clamp(never_val);
        path[0] = clamp(-131);
        path[10] = clamp(-589);
        path[11] = clamp(-589);
        path[12] = clamp(-589);
        path[1] = clamp(-412);
        base_prev = '0;
        base_prev2 = '0;
        cols_seen = 0;
    endfunction

    // advance the decoder by one column and queue its back-pointer groups
    function automatic void predict_column(logic [2:0] tb, logic signed [23:0] u5,
                                           logic signed [23:0] u3, logic signed [23:0] kz,
                                           logic signed [23:0] cd, logic lastc);
        longint  em[8];
        longint  nxt[ohv_pkg::NUM_ST];
        int      par[ohv_pkg::NUM_ST];
        longint  cand, bs;
        int      bst;
        bit      gap, stp;
        t_result r;
        gap = (tb == ohv_pkg::BASE_GAP);
        stp = 0;
        if (cols_seen >= 2 && base_prev2 == ohv_pkg::BASE_T) begin
            if (base_prev == ohv_pkg::BASE_A &&
                (tb == ohv_pkg::BASE_G || tb == ohv_pkg::BASE_A)) stp = 1;
            else if (base_prev == ohv_pkg::BASE_G && tb == ohv_pkg::BASE_A) stp = 1;
        end
        em[K_NONE] = 0;
        em[K_UTR5] = u5;
        em[K_UTR3] = u3;
        em[K_KOZ] = kz;
        em[K_CODON] = cd;
        em[K_NOTINS] = gap ? never_val : 0;
        em[K_ISINS] = gap ? 0 : never_val;
        em[K_STOP] = stp ? 0 : never_val;
        for (int s = 0; s < ohv_pkg::NUM_ST; s++) begin
            nxt[s] = longint'(SMIN);
            par[s] = ohv_pkg::NO_PARENT;
        end
        for (int e = 0; e < 42; e++) begin
            cand = clamp(longint'(e_tr[e]) + em[e_kind[e]] + path[e_src[e]]);
            if (cand > nxt[e_dst[e]]) begin
                nxt[e_dst[e]] = cand;
                par[e_dst[e]] = e_src[e];
            end
        end
        path = nxt;
        base_prev2 = base_prev;
        base_prev = tb;
        if (cols_seen < 2) cols_seen++;
        for (int g = 0; g < 4; g++) begin
            r.grp = g[2:0];
            for (int j = 0; j < 7; j++) r.parents[j*5 +: 5] = par[g*7+j][4:0];
            r.best = '0;
            r.score = '0;
            r.last = (g == 3) && !lastc;
            expected_results.push_back(r);
        end
        if (lastc) begin
            bst = 0;
            bs = path[0];
            for (int s = 1; s < ohv_pkg::NUM_ST; s++)
                if (path[s] > bs) begin
                    bs = path[s];
                    bst = s;
                end
            if (bs > 64'sd2147483647) bs = 64'sd2147483647;
            if (bs < -64'sd2147483648) bs = -64'sd2147483648;
            r.grp = 3'(ohv_pkg::GROUP_SUMMARY);
            for (int j = 0; j < 7; j++) r.parents[j*5 +: 5] = 5'(ohv_pkg::NO_PARENT);
            r.best = bst[4:0];
            r.score = bs[31:0];
            r.last = 1'b1;
            expected_results.push_back(r);
            restart_scores();
        end
    endfunction

    // idle pattern: quiet stretch with no gaps, otherwise ~14% idle
    bit quiet = 0;
    function automatic bit take_gap();
        return !quiet && ($urandom_range(99) < 14);
    endfunction

    // send one column request
    task automatic send_column(logic [2:0] tb, logic signed [23:0] u5, logic signed [23:0] u3,
                               logic signed [23:0] kz, logic signed [23:0] cd, logic lastc);
        while (take_gap()) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, cd, kz, u3, u5, tb};
        s_axis_tlast <= lastc;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_column(tb, u5, u3, kz, cd, lastc);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_never(int v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v[20:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        never_val = v;
        @(posedge i_clk);
    endtask

    function automatic logic signed [23:0] rand_emit();
        case ($urandom_range(5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'($urandom);
            default: return -$signed({12'b0, 12'($urandom)});
        endcase
    endfunction

    task automatic send_random(logic [2:0] tb, logic lastc);
        send_column(tb, rand_emit(), rand_emit(), rand_emit(), rand_emit(), lastc);
    endtask

    // extremes of emissions, base codes 0, 1 and 3 to 6, gaps, lone last column
    task automatic test_directed();
        send_column(ohv_pkg::BASE_T, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                    1'b0);
        send_column(3'd1, 24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, 1'b0);
        send_column(ohv_pkg::BASE_GAP, 24'sh000000, 24'shFFFFFF, 24'sh555555, 24'shAAAAAA,
                    1'b0);
        send_column(3'd4, 24'shAAAAAA, 24'sh555555, -24'sd100, 24'sd100, 1'b0);
        send_column(3'd6, -24'sd5, -24'sd7, -24'sd3, -24'sd9, 1'b1);
        send_column(ohv_pkg::BASE_G, 24'sh7FFFFF, 24'sh800000, 24'sd0, 24'sd0, 1'b1);
    endtask

    // each stop codon, plus a gap-broken near miss
    task automatic test_stop_codons();
        logic [2:0] seqs[4][3] = '{'{ohv_pkg::BASE_T, ohv_pkg::BASE_A, ohv_pkg::BASE_A},
                                   '{ohv_pkg::BASE_T, ohv_pkg::BASE_A, ohv_pkg::BASE_G},
                                   '{ohv_pkg::BASE_T, ohv_pkg::BASE_G, ohv_pkg::BASE_A},
                                   '{ohv_pkg::BASE_T, ohv_pkg::BASE_GAP, ohv_pkg::BASE_A}};
        for (int k = 0; k < 4; k++) begin
            send_column(3'd1, -24'sd10, -24'sd10, -24'sd10, 24'sd50, 1'b0);
            for (int j = 0; j < 3; j++)
                send_column(seqs[k][j], -24'sd20, -24'sd20, 24'sd30, 24'sd40, j == 2);
        end
        // stop right at the start of a run
        send_column(ohv_pkg::BASE_T, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0);
        send_column(ohv_pkg::BASE_A, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0);
        send_column(ohv_pkg::BASE_A, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b1);
    endtask

    // random runs with stop-rich base content
    task automatic test_random(int n);
        int len;
        int sent = 0;
        while (sent < n) begin
            len = $urandom_range(1, 12);
            for (int j = 0; j < len && sent < n; j++) begin
                if ($urandom_range(3) == 0)
                    send_random(3'($urandom_range(6)), j == len - 1);
                else
                    send_random($urandom_range(1) ? ohv_pkg::BASE_T :
                                ($urandom_range(1) ? ohv_pkg::BASE_A : ohv_pkg::BASE_G),
                                j == len - 1);
                sent++;
            end
            if ($urandom_range(30) == 0) drain();
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_result exp_r;
            if (expected_results.size() == 0) begin
                failed = 1;
                mismatches++;
                if (mismatches <= 10) $display("unexpected result group %0d", m_axis_tuser);
            end else begin
                exp_r = expected_results.pop_front();
                if (m_axis_tuser !== exp_r.grp || m_axis_tdata[34:0] !== exp_r.parents ||
                    m_axis_tdata[39:35] !== exp_r.best || m_axis_tdata[71:40] !== exp_r.score ||
                    m_axis_tlast !== exp_r.last) begin
                    failed = 1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp g%0d p%h b%0d s%0d l%b got g%0d p%h b%0d s%0d l%b",
                                 exp_r.grp, exp_r.parents, exp_r.best, $signed(exp_r.score),
                                 exp_r.last, m_axis_tuser, m_axis_tdata[34:0],
                                 m_axis_tdata[39:35], $signed(m_axis_tdata[71:40]), m_axis_tlast);
                end
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) m_axis_tready <= !take_gap();

    initial begin
        never_val = NEVER_RST;
        restart_scores();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_stop_codons();
        write_never(0);
        test_random(60);
        write_never(-1000000);
        test_random(60);
        write_never(-1048576);
        test_random(40);
        write_never(-1);
        quiet = 1;
        test_random(60);
        quiet = 0;
        write_never(-int'($urandom_range(1000000)));
        test_random(80);
        write_never(NEVER_RST);
        test_random(95);
        drain();
        if (!failed && expected_results.size() == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    initial begin
        #400000;
        $display("tb: failure");
        $finish;
    end
endmodule
